// ----- rtl/battery_voltage_to_charge_percent_assert.svh -----
// assertion macros shared by the rtl
`ifndef BATTERY_VOLTAGE_TO_CHARGE_PERCENT_ASSERT_SVH
`define BATTERY_VOLTAGE_TO_CHARGE_PERCENT_ASSERT_SVH
`ifndef SYNTHESIS
`define BVCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bvcp assertion failed");
`define BVCP_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("bvcp reset assertion failed");
`else
`define BVCP_ASSERT(label, clk, rst, prop)
`define BVCP_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- rtl/bvcp_pkg.sv -----
package bvcp_pkg;

   localparam int CURVE_POINTS = 21;
   localparam int MV_W         = 13;
   localparam int PCT_W        = 7;
   localparam int IDX_W        = $clog2(CURVE_POINTS);
   localparam int PROD_W       = MV_W + PCT_W;
   localparam int NUM_W        = PROD_W + 2;
   localparam int DEN_W        = MV_W + 1;
   localparam int DIV_STEPS    = PCT_W;

   typedef logic [MV_W-1:0]  mv_type;
   typedef logic [PCT_W-1:0] pct_type;

   localparam pct_type PCT_FULL = 7'd100;

   // discharge curve, falling from full to empty
   localparam mv_type CURVE_MV [CURVE_POINTS] = '{
      13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950,
      13'd3910, 13'd3870, 13'd3850, 13'd3840, 13'd3820, 13'd3800, 13'd3790,
      13'd3770, 13'd3750, 13'd3730, 13'd3690, 13'd3610, 13'd3500, 13'd3270
   };

   localparam pct_type CURVE_PCT [CURVE_POINTS] = '{
      7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
      7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
      7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
   };

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      pct_type          quo;
      pct_type          base;
   } div_stage_type;

endpackage

// ----- rtl/battery_voltage_to_charge_percent.sv -----
// battery state of charge from voltage
//
// req channel: one transfer per voltage sample, req_tdata[12:0] in millivolts.
// rsp channel: one transfer per sample, rsp_tdata[6:0] charge in percent
// (0..100), rounded half up, interpolated on a fixed 21-point discharge curve.
// results leave in the order the samples came in.
//
// one stage finds the curve segment, one forms the interpolation numerator,
// and a restoring divider takes one quotient bit per stage over 7 stages, the
// last of which is the output register. throughput is one sample per cycle
// while rsp_tready stays high.
//
// reset empties the pipeline; rsp_tvalid drops and req_tready rises.
// when the receiver holds rsp_tready low, the output holds its result and
// the stages behind it keep moving until they are full, so empty stages
// still take new samples; only a full pipeline drops req_tready.
`include "battery_voltage_to_charge_percent_assert.svh"

module battery_voltage_to_charge_percent (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [12:0] voltage_mv
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [6:0] charge_percent
);

   import bvcp_pkg::*;

   localparam int N_ST = DIV_STEPS + 2;

   logic [N_ST-1:0] valid_ff, valid_in, valid_src, adv;

   // stage a: segment search
   mv_type           a_v_ff;
   logic [IDX_W-1:0] a_seg_ff, a_seg_in;
   logic             a_found_ff, a_found_in;
   logic             a_hi_ff, a_hi_in;
   logic             a_lo_ff, a_lo_in;
   mv_type           req_v;

   // stage b onward: divider stages
   div_stage_type    d_ff [DIV_STEPS];
   div_stage_type    d_in;
   div_stage_type    step_out [DIV_STEPS];

   pct_type          rsp_pct_ff, rsp_pct_in;

   // stall chain: a stage moves when empty or when the one after moves
   always_comb begin
      adv[N_ST-1] = !valid_ff[N_ST-1] || rsp_tready;
      for (int i = N_ST - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_src = {valid_ff[N_ST-2:0], req_tvalid};
      for (int i = 0; i < N_ST; i++) begin
         valid_in[i] = adv[i] ? valid_src[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[N_ST-1];
   assign rsp_tdata  = {1'b0, rsp_pct_ff};

   // stage a
   always_comb begin
      req_v      = req_tdata[MV_W-1:0];
      a_hi_in    = req_v >= CURVE_MV[0];
      a_lo_in    = req_v <= CURVE_MV[CURVE_POINTS-1];
      a_found_in = 1'b0;
      a_seg_in   = '0;
      for (int k = 0; k < CURVE_POINTS - 1; k++) begin
         if (!a_found_in && req_v >= CURVE_MV[k+1] && req_v <= CURVE_MV[k]) begin
            a_found_in = 1'b1;
            a_seg_in   = IDX_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_v_ff     <= req_v;
         a_seg_ff   <= a_seg_in;
         a_found_ff <= a_found_in;
         a_hi_ff    <= a_hi_in;
         a_lo_ff    <= a_lo_in;
      end
   end

   // stage b: numerator and divisor for the rounded quotient
   logic [IDX_W-1:0]  b_lo_idx;
   mv_type            b_vh, b_vl, b_dv, b_diff;
   pct_type           b_sh, b_sl, b_ds;
   logic [PROD_W-1:0] b_prod;

   always_comb begin
      b_lo_idx = a_seg_ff + IDX_W'(1);
      b_vh     = CURVE_MV[a_seg_ff];
      b_vl     = CURVE_MV[b_lo_idx];
      b_sh     = CURVE_PCT[a_seg_ff];
      b_sl     = CURVE_PCT[b_lo_idx];
      b_dv     = b_vh - b_vl;
      b_ds     = (b_sh >= b_sl) ? (b_sh - b_sl) : '0;
      b_diff   = a_v_ff - b_vl;
      b_prod   = PROD_W'(b_diff) * PROD_W'(b_ds);

      d_in.quo = '0;
      d_in.rem = '0;
      d_in.den = DEN_W'(1);
      if (a_hi_ff) begin
         d_in.base = PCT_FULL;
      end else if (a_lo_ff || !a_found_ff) begin
         d_in.base = '0;
      end else if (b_dv == '0) begin
         d_in.base = b_sl;
      end else begin
         d_in.base = b_sl;
         d_in.rem  = {1'b0, b_prod, 1'b0} + NUM_W'(b_dv);
         d_in.den  = {b_dv, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         d_ff[0] <= d_in;
      end
   end

   // restoring divider, one quotient bit per stage, msb first
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int BIT = DIV_STEPS - 1 - j;
      logic [NUM_W-1:0] shifted;

      always_comb begin
         shifted     = NUM_W'(d_ff[j].den) << BIT;
         step_out[j] = d_ff[j];
         if (d_ff[j].rem >= shifted) begin
            step_out[j].rem      = d_ff[j].rem - shifted;
            step_out[j].quo[BIT] = 1'b1;
         end
      end

      if (j < DIV_STEPS - 1) begin : g_reg
         always_ff @(posedge clock) begin
            if (adv[j+2]) begin
               d_ff[j+1] <= step_out[j];
            end
         end
      end
   end

   // output stage
   logic [PCT_W:0] out_sum;

   always_comb begin
      out_sum    = {1'b0, step_out[DIV_STEPS-1].base} + {1'b0, step_out[DIV_STEPS-1].quo};
      rsp_pct_in = (out_sum > {1'b0, PCT_FULL}) ? PCT_FULL : out_sum[PCT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[N_ST-1]) begin
         rsp_pct_ff <= rsp_pct_in;
      end
   end

   `BVCP_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_tvalid)
   `BVCP_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)
   `BVCP_ASSERT(a_pct_range, clock, reset, rsp_tvalid |-> rsp_pct_ff <= PCT_FULL)
   `BVCP_ASSERT(a_div_rem, clock, reset,
      valid_ff[N_ST-2] |-> step_out[DIV_STEPS-1].rem < NUM_W'(d_ff[DIV_STEPS-1].den))

endmodule

// ----- dv/battery_voltage_to_charge_percent_checker.sv -----
`timescale 1ns / 100ps

module battery_voltage_to_charge_percent_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [12:0] voltage_mv
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [6:0] charge_percent
   output int          fail_count,
   output int          pending_count
);

   import bvcp_pkg::*;

   localparam int KNEES = 21;

   // discharge curve knees, full to empty
   localparam int KNEE_MV [KNEES] = '{
      4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910, 3870, 3850, 3840,
      3820, 3800, 3790, 3770, 3750, 3730, 3690, 3610, 3500, 3270
   };
   localparam int KNEE_PCT [KNEES] = '{
      100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
      45, 40, 35, 30, 25, 20, 15, 10, 5, 0
   };

   pct_type expected_charge_q [$];
   pct_type oldest_charge;

   function automatic pct_type charge_from_voltage(mv_type voltage);
      int  mv;
      int  span;
      int  rise;
      int  charge;
      bit  found;
      mv     = int'(voltage);
      charge = 0;
      found  = 1'b0;
      if (mv >= KNEE_MV[0]) begin
         charge = 100;
      end else if (mv > KNEE_MV[KNEES-1]) begin
         for (int k = 0; k < KNEES - 1; k++) begin
            if (!found && mv >= KNEE_MV[k+1] && mv <= KNEE_MV[k]) begin
               found = 1'b1;
               span  = KNEE_MV[k] - KNEE_MV[k+1];
               rise  = (KNEE_PCT[k] >= KNEE_PCT[k+1]) ? KNEE_PCT[k] - KNEE_PCT[k+1] : 0;
               if (span == 0) begin
                  charge = KNEE_PCT[k+1];
               end else begin
                  // rounded half up
                  charge = KNEE_PCT[k+1]
                         + (2 * (mv - KNEE_MV[k+1]) * rise + span) / (2 * span);
               end
            end
         end
      end
      if (charge > 100) begin
         charge = 100;
      end
      return pct_type'(charge);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_charge_q.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_charge_q.size() == 0) begin
               $display("%0t: charge_percent expected none, actual %0d", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               oldest_charge = expected_charge_q.pop_front();
               if (rsp_tdata !== {1'b0, oldest_charge}) begin
                  $display("%0t: charge_percent expected %0d, actual %0d",
                           $time, oldest_charge, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_charge_q.push_back(charge_from_voltage(req_tdata[MV_W-1:0]));
         end
         pending_count <= expected_charge_q.size();
      end
   end

endmodule

// ----- dv/tb_battery_voltage_to_charge_percent.sv -----
`timescale 1ns / 100ps

module tb_battery_voltage_to_charge_percent;
   import bvcp_pkg::*;

   localparam int RANDOM_ITEMS   = 1930;
   localparam int CALM_ITEMS     = 200;
   localparam int HOLD_OFF_AT    = 300;
   localparam int HOLD_OFF_LEN   = 120;
   localparam int DRAIN_CYCLES   = 20;
   localparam int QUIET_LIMIT    = 2000;

   localparam mv_type CORNER_MV [22] = '{
      13'd0,    13'd8191, 13'd4200, 13'd4201, 13'd4199, 13'd3270, 13'd3271,
      13'd3269, 13'd4150, 13'd3840, 13'd3500, 13'd3505, 13'd3511, 13'd3555,
      13'd3845, 13'd3610, 13'd3690, 13'd4000, 13'd1,    13'd4096, 13'd5461,
      13'd2730
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [12:0] voltage_mv
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [6:0] charge_percent

   int fail_count;
   int pending_count;
   int quiet_cycles = 0;
   bit idle_enabled = 1'b1;
   bit hold_off_due = 1'b0;
   bit hold_off_done = 1'b0;

   always #5 clock = ~clock;

   battery_voltage_to_charge_percent u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   battery_voltage_to_charge_percent_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   task automatic send_voltage(mv_type voltage);
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, voltage};
      do @(posedge clock); while (!req_tready);
   endtask

   // receiver: random stalls, one long hold-off to back the pipeline up
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_due && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
         end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int     knee_mv;
      mv_type voltage;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (CORNER_MV[i]) begin
         send_voltage(CORNER_MV[i]);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == HOLD_OFF_AT) begin
            hold_off_due = 1'b1;
         end
         if (i == RANDOM_ITEMS - CALM_ITEMS) begin
            idle_enabled = 1'b0;
         end
         case ($urandom_range(0, 9))
            0, 1: voltage = mv_type'($urandom_range(0, 8191));
            2: begin
               // close around a curve knee
               knee_mv = int'(CURVE_MV[$urandom_range(0, CURVE_POINTS - 1)]);
               voltage = mv_type'(knee_mv + $urandom_range(0, 4) - 2);
            end
            default: voltage = mv_type'($urandom_range(3260, 4210));
         endcase
         send_voltage(voltage);
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
